// File: hw/rtl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Shared constants and types for the array list engine.
// ----------------------------------------------------------------------------
package ale_pkg;

    localparam int DEPTH_DEFAULT     = 64;
    localparam int WORD_BITS_DEFAULT = 32;

    localparam int CMD_W = 3;
    localparam int POS_W = 7;
    localparam int DW    = 32;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PREPEND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_FIND    = 3'd6;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd7;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_BADIDX = 2'd3;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_REM  = 2'd3;

    typedef struct packed {
        logic [1:0] op;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/ale_cell.sv
// ----------------------------------------------------------------------------
// ale_cell
// One list slot: holds a word, shifts from its neighbours, flags a match.
// ----------------------------------------------------------------------------
module ale_cell
    import ale_pkg::*;
#(
    parameter int IW        = 7,
    parameter int WORD_BITS = WORD_BITS_DEFAULT,
    parameter int IDX       = 0
)
(
    input  logic                 clk,
    input  cell_ctrl_t           ctrl,
    input  logic [IW-1:0]        pos,
    input  logic [IW-1:0]        count,
    input  logic [WORD_BITS-1:0] val,
    input  logic [WORD_BITS-1:0] left_word,
    input  logic [WORD_BITS-1:0] right_word,
    input  logic                 prefix_in,
    output logic [WORD_BITS-1:0] word,
    output logic                 prefix_out,
    output logic                 first,
    output logic [WORD_BITS-1:0] sel_word
);

    localparam logic [IW-1:0] ME      = IW'(IDX);
    localparam logic [IW:0]   ME_NEXT = (IW+1)'(IDX + 1);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 live;
    logic                 hit;
    logic                 below_top;

    assign live       = ME < count;
    assign hit        = live && (word_reg == val);
    assign prefix_out = prefix_in | hit;
    assign first      = hit & ~prefix_in;
    assign below_top  = ME_NEXT < {1'b0, count};
    assign sel_word   = (ME == pos) ? word_reg : '0;
    assign word       = word_reg;

    always_comb
    begin
        word_next = word_reg;
        case (ctrl.op)
            OP_INS:
            begin
                if (ME == pos)
                    word_next = val;
                else if (ME > pos && ME <= count)
                    word_next = left_word;
            end
            OP_DEL:
            begin
                if (ME >= pos && below_top)
                    word_next = right_word;
            end
            OP_REM:
            begin
                // everything from the first match onwards moves down one slot
                if (prefix_out && below_top)
                    word_next = right_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

// File: hw/rtl/array_list_engine_top.sv
// ----------------------------------------------------------------------------
// array_list_engine_top
// Ordered list of signed words held in a chain of slot cells.
// ----------------------------------------------------------------------------
// Push, insert, prepend, pop, delete, find and read are accepted and their
// result appears in the output register on the same edge. Remove-by-value
// latches the value on the accepting edge, then drops the first matching
// entry from the cell chain each cycle and reports once no match is left
// and the output slot is free; no new transaction is accepted meanwhile. A
// new transaction is accepted while a result is pending only if that result
// is taken in the same cycle.
module array_list_engine_top
    import ale_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CMD_W-1:0]        cmd,
    input  logic [POS_W-1:0]        position,
    input  logic signed [DW-1:0]    data_word,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [DW-1:0]    read_word,
    output logic signed [POS_W-1:0] match_index,
    output logic [POS_W-1:0]        removed_count,
    output logic [POS_W-1:0]        live_count,
    output logic                    empty_flag,
    output logic [ST_W-1:0]         status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > POS_W) ? CW : POS_W;
    localparam logic [IW-1:0] FULL_COUNT = IW'(DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_REM  = 1'b1;

    logic                 state_reg, state_next;
    logic [IW-1:0]        count_reg, count_next;
    logic [IW-1:0]        removed_reg, removed_next;
    logic [WORD_BITS-1:0] val_reg;

    logic                    out_valid_reg, out_valid_next;
    logic signed [DW-1:0]    read_word_reg, read_word_next;
    logic signed [POS_W-1:0] match_reg, match_next;
    logic [POS_W-1:0]        removed_out_reg, removed_out_next;
    logic [POS_W-1:0]        live_reg, live_next;
    logic                    empty_reg, empty_next;
    logic [ST_W-1:0]         status_reg, status_next;

    logic                 accept;
    logic                 slot_free;
    logic signed [63:0]   word_wide;
    logic [WORD_BITS-1:0] in_val;
    logic [WORD_BITS-1:0] cell_val;
    logic [IW-1:0]        pos_ext;
    logic [IW-1:0]        cell_pos;
    cell_ctrl_t           ctrl;
    logic [ST_W-1:0]      st;
    logic [WORD_BITS-1:0] rd_sel;
    logic [IW-1:0]        find_idx;
    logic                 any_hit;
    logic signed [63:0]   rd_wide;

    logic [WORD_BITS-1:0] words  [DEPTH];
    logic [WORD_BITS-1:0] sels   [DEPTH];
    logic                 firsts [DEPTH];
    logic [DEPTH:0]       prefix;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;

    assign word_wide = 64'(data_word);
    assign in_val    = word_wide[WORD_BITS-1:0];
    assign pos_ext   = IW'(position);
    assign cell_val  = (state_reg == S_REM) ? val_reg : in_val;
    assign prefix[0] = 1'b0;
    assign any_hit   = prefix[DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [WORD_BITS-1:0] left_w;
            logic [WORD_BITS-1:0] right_w;
            if (g == 0)
            begin : g_head
                assign left_w = '0;
            end
            else
            begin : g_mid
                assign left_w = words[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_tail
                assign right_w = '0;
            end
            else
            begin : g_body
                assign right_w = words[g+1];
            end
            ale_cell #(
                .IW        (IW),
                .WORD_BITS (WORD_BITS),
                .IDX       (g)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .pos        (cell_pos),
                .count      (count_reg),
                .val        (cell_val),
                .left_word  (left_w),
                .right_word (right_w),
                .prefix_in  (prefix[g]),
                .word       (words[g]),
                .prefix_out (prefix[g+1]),
                .first      (firsts[g]),
                .sel_word   (sels[g])
            );
        end
    endgenerate

    // one-hot reductions across the chain
    always_comb
    begin
        rd_sel   = '0;
        find_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_sel = rd_sel | sels[i];
            if (firsts[i])
                find_idx = find_idx | IW'(i);
        end
    end

    // request decode against the current count
    always_comb
    begin
        st       = ST_OK;
        cell_pos = pos_ext;
        case (cmd)
            CMD_PUSH, CMD_INSERT, CMD_PREPEND:
            begin
                if (cmd == CMD_PUSH)
                    cell_pos = count_reg;
                else if (cmd == CMD_PREPEND)
                    cell_pos = '0;
                if (count_reg == FULL_COUNT)
                    st = ST_FULL;
                else if (cmd == CMD_INSERT && pos_ext > count_reg)
                    st = ST_BADIDX;
            end
            CMD_POP:
            begin
                cell_pos = count_reg - 1'b1;
                if (count_reg == '0)
                    st = ST_EMPTY;
            end
            CMD_DELETE, CMD_READ:
            begin
                if (count_reg == '0)
                    st = ST_EMPTY;
                else if (pos_ext >= count_reg)
                    st = ST_BADIDX;
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    assign rd_wide = 64'(signed'(rd_sel));

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        removed_next     = removed_reg;
        ctrl.op          = OP_NONE;
        out_valid_next   = out_valid_reg && !out_ready;
        read_word_next   = read_word_reg;
        match_next       = match_reg;
        removed_out_next = removed_out_reg;
        live_next        = live_reg;
        empty_next       = empty_reg;
        status_next      = status_reg;

        if (state_reg == S_REM)
        begin
            if (any_hit)
            begin
                ctrl.op      = OP_REM;
                count_next   = count_reg - 1'b1;
                removed_next = removed_reg + 1'b1;
            end
            else if (slot_free)
            begin
                state_next       = S_IDLE;
                out_valid_next   = 1'b1;
                read_word_next   = '0;
                match_next       = '1;
                removed_out_next = removed_reg[POS_W-1:0];
                live_next        = count_reg[POS_W-1:0];
                empty_next       = count_reg == '0;
                status_next      = ST_OK;
            end
        end
        else if (accept)
        begin
            read_word_next   = '0;
            match_next       = '1;
            removed_out_next = '0;
            status_next      = st;
            out_valid_next   = 1'b1;
            if (st == ST_OK)
            begin
                case (cmd)
                    CMD_PUSH, CMD_INSERT, CMD_PREPEND:
                    begin
                        ctrl.op    = OP_INS;
                        count_next = count_reg + 1'b1;
                    end
                    CMD_POP:
                    begin
                        count_next     = count_reg - 1'b1;
                        read_word_next = rd_wide[DW-1:0];
                    end
                    CMD_DELETE:
                    begin
                        ctrl.op    = OP_DEL;
                        count_next = count_reg - 1'b1;
                    end
                    CMD_REMOVE:
                    begin
                        state_next     = S_REM;
                        removed_next   = '0;
                        out_valid_next = 1'b0;
                    end
                    CMD_FIND:
                    begin
                        if (any_hit)
                            match_next = find_idx[POS_W-1:0];
                    end
                    default:
                    begin
                        read_word_next = rd_wide[DW-1:0];
                    end
                endcase
            end
            live_next  = count_next[POS_W-1:0];
            empty_next = count_next == '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg     <= removed_next;
        read_word_reg   <= read_word_next;
        match_reg       <= match_next;
        removed_out_reg <= removed_out_next;
        live_reg        <= live_next;
        empty_reg       <= empty_next;
        status_reg      <= status_next;
        if (accept)
            val_reg <= in_val;
    end

    assign out_valid     = out_valid_reg;
    assign read_word     = read_word_reg;
    assign match_index   = match_reg;
    assign removed_count = removed_out_reg;
    assign live_count    = live_reg;
    assign empty_flag    = empty_reg;
    assign status        = status_reg;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the array list engine: a queued driver and a
// monitor with random idling on both sides, checked against a behavioural
// list predictor.
// ----------------------------------------------------------------------------
module tb;
    import ale_pkg::*;

    localparam int NDEPTH     = DEPTH_DEFAULT;
    localparam int N_RANDOM   = 1350;
    localparam int CYCLE_CAP  = 400000;

    typedef struct packed {
        logic [CMD_W-1:0]     op;
        logic [POS_W-1:0]     idx;
        logic signed [DW-1:0] word;
    } request_t;

    typedef struct packed {
        logic signed [DW-1:0]    rd;
        logic signed [POS_W-1:0] hit;
        logic [POS_W-1:0]        dropped;
        logic [POS_W-1:0]        count;
        logic                    empty;
        logic [ST_W-1:0]         st;
    } reply_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] position;
    logic signed [DW-1:0] data_word;
    logic out_valid;
    logic out_ready;
    logic signed [DW-1:0] read_word;
    logic signed [POS_W-1:0] match_index;
    logic [POS_W-1:0] removed_count;
    logic [POS_W-1:0] live_count;
    logic empty_flag;
    logic [ST_W-1:0] status;

    array_list_engine_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .position(position), .data_word(data_word),
        .out_valid(out_valid), .out_ready(out_ready),
        .read_word(read_word), .match_index(match_index),
        .removed_count(removed_count), .live_count(live_count),
        .empty_flag(empty_flag), .status(status)
    );

    request_t pending_reqs[$];
    reply_t   expected_replies[$];

    logic signed [DW-1:0] list_words[NDEPTH];
    int unsigned list_len;

    int unsigned mismatches;
    int unsigned replies_seen;
    int unsigned cycles;
    bit          calm;   // no idling in the closing stretch
    bit          hold_send;
    int unsigned send_gap;
    int unsigned recv_gap;
    int unsigned op_tally[8];

    // Behavioural list: applies one request and returns the reply it gives
    function automatic reply_t list_apply(request_t r);
        reply_t e;
        int unsigned p;
        int unsigned k;
        e = '0;
        e.hit = '1;
        e.st = ST_OK;
        p = r.idx;
        case (r.op)
            CMD_PUSH, CMD_INSERT, CMD_PREPEND:
            begin
                if (list_len >= NDEPTH)
                    e.st = ST_FULL;
                else
                begin
                    if (r.op == CMD_PUSH)
                        p = list_len;
                    else if (r.op == CMD_PREPEND)
                        p = 0;
                    if (p > list_len)
                        e.st = ST_BADIDX;
                    else
                    begin
                        for (int i = list_len; i > p; i--)
                            list_words[i] = list_words[i-1];
                        list_words[p] = r.word;
                        list_len++;
                    end
                end
            end
            CMD_POP:
            begin
                if (list_len == 0)
                    e.st = ST_EMPTY;
                else
                begin
                    list_len--;
                    e.rd = list_words[list_len];
                end
            end
            CMD_DELETE, CMD_READ:
            begin
                if (list_len == 0)
                    e.st = ST_EMPTY;
                else if (p >= list_len)
                    e.st = ST_BADIDX;
                else if (r.op == CMD_READ)
                    e.rd = list_words[p];
                else
                begin
                    for (int i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            CMD_REMOVE:
            begin
                k = 0;
                for (int i = 0; i < list_len; i++)
                    if (list_words[i] != r.word)
                    begin
                        list_words[k] = list_words[i];
                        k++;
                    end
                e.dropped = POS_W'(list_len - k);
                list_len = k;
            end
            default:
            begin
                for (int i = 0; i < list_len; i++)
                    if (list_words[i] == r.word)
                    begin
                        e.hit = POS_W'(i);
                        break;
                    end
            end
        endcase
        e.count = POS_W'(list_len);
        e.empty = (list_len == 0);
        return e;
    endfunction

    task automatic queue_req(logic [CMD_W-1:0] op, logic [POS_W-1:0] idx,
                             logic signed [DW-1:0] word);
        request_t r;
        r.op = op;
        r.idx = idx;
        r.word = word;
        pending_reqs.push_back(r);
    endtask

    // Small value pool so that finds and removes actually hit
    function automatic logic signed [DW-1:0] pick_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 7);
            2: return 32'sd0 - DW'($urandom_range(1, 4));
            default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cmd       <= CMD_PUSH;
            position  <= '0;
            data_word <= '0;
            send_gap  <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_replies.push_back(
                    list_apply(request_t'{cmd, position, data_word}));
                op_tally[cmd]++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    send_gap <= $urandom_range(1, 17);
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0 && !hold_send)
                begin
                    request_t r;
                    r = pending_reqs.pop_front();
                    in_valid  <= 1'b1;
                    cmd       <= r.op;
                    position  <= r.idx;
                    data_word <= r.word;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                reply_t got;
                reply_t want;
                got = '{read_word, match_index, removed_count, live_count,
                        empty_flag, status};
                replies_seen++;
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: %p", got);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at reply %0d: exp %p got %p",
                                     replies_seen, want, got);
                    end
                end
            end
            if (recv_gap != 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                recv_gap  <= $urandom_range(1, 17);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned fill;
        int unsigned sz;
        list_len = 0;
        mismatches = 0;
        replies_seen = 0;
        cycles = 0;
        calm = 1'b0;
        hold_send = 1'b0;
        foreach (op_tally[i])
            op_tally[i] = 0;
        foreach (list_words[i])
            list_words[i] = '0;

        // Directed: empty store rejections, extremes, every command
        queue_req(CMD_POP, 0, 0);
        queue_req(CMD_DELETE, 0, 0);
        queue_req(CMD_READ, 0, 0);
        queue_req(CMD_FIND, 0, 5);
        queue_req(CMD_REMOVE, 0, 5);
        queue_req(CMD_INSERT, 1, 9);               // beyond count
        queue_req(CMD_INSERT, 0, 32'sh7fffffff);
        queue_req(CMD_PUSH, 127, 32'sh80000000);
        queue_req(CMD_PREPEND, 0, -1);
        queue_req(CMD_INSERT, 3, 0);               // at count: append
        queue_req(CMD_READ, 3, 0);
        queue_req(CMD_READ, 4, 0);                 // bad index
        queue_req(CMD_DELETE, 127, 0);
        queue_req(CMD_FIND, 0, 32'sh80000000);
        queue_req(CMD_FIND, 0, 12345);
        queue_req(CMD_DELETE, 1, 0);
        queue_req(CMD_REMOVE, 0, -1);
        queue_req(CMD_POP, 0, 0);
        // Fill to capacity, then overflow each way
        for (int i = 0; i < NDEPTH; i++)
            queue_req(CMD_PUSH, 0, i % 3);
        queue_req(CMD_PUSH, 0, 1);
        queue_req(CMD_INSERT, 0, 1);
        queue_req(CMD_PREPEND, 0, 1);
        queue_req(CMD_READ, 63, 0);
        queue_req(CMD_REMOVE, 0, 0);               // large compaction
        queue_req(CMD_REMOVE, 0, 1);

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Random phase; fill level drifts between nearly empty and full
        n = 0;
        while (n < N_RANDOM)
        begin
            fill = $urandom_range(0, 3);
            sz = $urandom_range(10, 60);
            for (int j = 0; j < sz && n < N_RANDOM; j++, n++)
            begin
                logic [CMD_W-1:0] op;
                logic [POS_W-1:0] idx;
                if ($urandom_range(0, 3) < fill || $urandom_range(0, 1) == 0)
                    op = CMD_W'($urandom_range(0, 2));
                else
                    op = CMD_W'($urandom_range(3, 7));
                idx = ($urandom_range(0, 15) == 0) ? POS_W'($urandom)
                                                   : POS_W'($urandom_range(0, 40));
                queue_req(op, idx, pick_word());
            end
            // extra find for zero around the middle of the run
            if (n > N_RANDOM / 2 && n < N_RANDOM / 2 + 61)
                queue_req(CMD_FIND, 0, 0);
        end

        wait (pending_reqs.size() < N_RANDOM / 2);
        hold_send = 1'b1;
        wait (!in_valid && expected_replies.size() == 0);
        repeat (3) @(posedge clk);
        hold_send = 1'b0;

        wait (pending_reqs.size() < 150);
        calm = 1'b1;
        wait (pending_reqs.size() == 0 && !in_valid);
        wait (expected_replies.size() == 0);
        repeat (NDEPTH + 10) @(posedge clk);

        $display("replies checked: %0d, mismatches: %0d", replies_seen, mismatches);
        $display("per command: %p", op_tally);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// File: array_list_engine_top.f
hw/rtl/ale_pkg.sv
hw/rtl/ale_cell.sv
hw/rtl/array_list_engine_top.sv
verif/tb.sv
